### design/rn_pkg.sv
`timescale 1ns / 1ps
package rn_pkg;

  localparam int unsigned VALUE_W = 13;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned NDIGITS = 4;
  localparam int unsigned REM_W   = VALUE_W + 1;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [1:0]         pos_t;
  typedef logic [REM_W-1:0]   rem_t;

  localparam value_t MAX_VALUE = 13'd4999;

  localparam pos_t POS_UNITS     = 2'd0;
  localparam pos_t POS_TENS      = 2'd1;
  localparam pos_t POS_HUNDREDS  = 2'd2;
  localparam pos_t POS_THOUSANDS = 2'd3;

  localparam char_t CHAR_NONE = 7'h00;
  localparam char_t CHAR_M    = 7'h4D;
  localparam char_t CHAR_D    = 7'h44;
  localparam char_t CHAR_C    = 7'h43;
  localparam char_t CHAR_L    = 7'h4C;
  localparam char_t CHAR_X    = 7'h58;
  localparam char_t CHAR_V    = 7'h56;
  localparam char_t CHAR_I    = 7'h49;

  typedef struct packed {
    logic                       oor;
    logic [NDIGITS-1:0][DIGIT_W-1:0] dig;
  } rn_entry_t;

  function automatic rem_t digit_weight(input pos_t pos);
    rem_t w;
    unique case (pos)
      POS_THOUSANDS: w = 14'd1000;
      POS_HUNDREDS:  w = 14'd100;
      POS_TENS:      w = 14'd10;
      default:       w = 14'd1;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] digit_len(input pos_t pos, input digit_t d);
    logic [2:0] len;
    if (pos == POS_THOUSANDS) begin
      len = d[2:0];
    end else begin
      unique case (d)
        4'd1, 4'd5:               len = 3'd1;
        4'd2, 4'd4, 4'd6, 4'd9:   len = 3'd2;
        4'd3, 4'd7:               len = 3'd3;
        4'd8:                     len = 3'd4;
        default:                  len = 3'd0;
      endcase
    end
    return len;
  endfunction

  function automatic char_t sym_one(input pos_t pos);
    char_t c;
    unique case (pos)
      POS_UNITS:    c = CHAR_I;
      POS_TENS:     c = CHAR_X;
      POS_HUNDREDS: c = CHAR_C;
      default:      c = CHAR_M;
    endcase
    return c;
  endfunction

  function automatic char_t sym_five(input pos_t pos);
    char_t c;
    unique case (pos)
      POS_UNITS: c = CHAR_V;
      POS_TENS:  c = CHAR_L;
      default:   c = CHAR_D;
    endcase
    return c;
  endfunction

  function automatic char_t sym_ten(input pos_t pos);
    char_t c;
    unique case (pos)
      POS_UNITS: c = CHAR_X;
      POS_TENS:  c = CHAR_C;
      default:   c = CHAR_M;
    endcase
    return c;
  endfunction

  function automatic char_t digit_char(input pos_t pos, input digit_t d,
                                       input logic [1:0] k);
    char_t c;
    if (pos == POS_THOUSANDS) begin
      c = CHAR_M;
    end else if (d == 4'd4) begin
      c = (k == 2'd0) ? sym_one(pos) : sym_five(pos);
    end else if (d == 4'd9) begin
      c = (k == 2'd0) ? sym_one(pos) : sym_ten(pos);
    end else if (d >= 4'd5) begin
      c = (k == 2'd0) ? sym_five(pos) : sym_one(pos);
    end else begin
      c = sym_one(pos);
    end
    return c;
  endfunction

endpackage

### design/rn_if.sv
`timescale 1ns / 1ps
interface rn_in_if;
  logic            valid;
  logic            ready;
  rn_pkg::value_t  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rn_out_if;
  logic            valid;
  logic            ready;
  rn_pkg::char_t   numeral_char;
  logic            out_of_range;
  logic            last_char;

  modport source (output valid, output numeral_char, output out_of_range,
                  output last_char, input ready);
  modport sink   (input valid, input numeral_char, input out_of_range,
                  input last_char, output ready);
endinterface

### design/rn_front.sv
`timescale 1ns / 1ps
module rn_front (
  input  logic              clk,
  input  logic              rst_n,
  rn_in_if.sink             in_ch,
  output logic              push,
  output rn_pkg::rn_entry_t push_entry,
  input  logic              full
);
  import rn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SPLIT = 3'b010,
    ST_PUSH  = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;
  value_t       rem_r, rem_nxt;
  pos_t         pos_r, pos_nxt;
  rn_entry_t    entry_r, entry_nxt;

  rem_t         weight;
  rem_t         thr;
  digit_t       dig;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign push        = (state_r == ST_PUSH);
  assign push_entry  = entry_r;

  always_comb begin
    weight = digit_weight(pos_r);
    dig    = '0;
    thr    = '0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, rem_r} >= REM_W'(k) * weight) begin
        dig = DIGIT_W'(k);
        thr = REM_W'(k) * weight;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    entry_nxt = entry_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.value == '0 || in_ch.value > MAX_VALUE) begin
            entry_nxt.oor = 1'b1;
            entry_nxt.dig = '0;
            state_nxt     = ST_PUSH;
          end else begin
            entry_nxt.oor = 1'b0;
            rem_nxt       = in_ch.value;
            pos_nxt       = POS_THOUSANDS;
            state_nxt     = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        entry_nxt.dig[pos_r] = dig;
        rem_nxt              = rem_r - thr[VALUE_W-1:0];
        if (pos_r == POS_TENS) begin
          entry_nxt.dig[POS_UNITS] = rem_nxt[DIGIT_W-1:0];
          state_nxt                = ST_PUSH;
        end else begin
          pos_nxt = pos_r - 2'd1;
        end
      end
      ST_PUSH: begin
        if (!full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    pos_r   <= pos_nxt;
    entry_r <= entry_nxt;
  end

endmodule

### design/rn_queue.sv
`timescale 1ns / 1ps
module rn_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rn_pkg::rn_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output rn_pkg::rn_entry_t head,
  output logic              empty
);
  import rn_pkg::*;

  rn_entry_t  slot_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? !wr_r : wr_r;
    rd_nxt  = do_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

endmodule

### design/rn_back.sv
`timescale 1ns / 1ps
module rn_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rn_pkg::rn_entry_t head,
  input  logic              empty,
  output logic              pop,
  rn_out_if.source          out_ch
);
  import rn_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  char_t            out_char_r, out_char_nxt;
  logic             out_oor_r, out_oor_nxt;
  logic             out_last_r, out_last_nxt;
  logic             started_r, started_nxt;
  logic [NDIGITS-1:0] mask_r, mask_nxt;
  logic [1:0]       k_r, k_nxt;

  logic               load, emit;
  logic [NDIGITS-1:0] head_mask, eff_mask, rest_mask;
  pos_t               pos;
  digit_t             d;
  logic [2:0]         len;
  logic               end_dig, last;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.numeral_char = out_char_r;
  assign out_ch.out_of_range = out_oor_r;
  assign out_ch.last_char    = out_last_r;

  always_comb begin
    for (int p = 0; p < NDIGITS; p++) begin
      head_mask[p] = (head.dig[p] != '0);
    end
    eff_mask = started_r ? mask_r : head_mask;
    if (eff_mask[3]) begin
      pos = POS_THOUSANDS;
    end else if (eff_mask[2]) begin
      pos = POS_HUNDREDS;
    end else if (eff_mask[1]) begin
      pos = POS_TENS;
    end else begin
      pos = POS_UNITS;
    end
    d         = head.dig[pos];
    len       = digit_len(pos, d);
    end_dig   = ({1'b0, k_r} + 3'd1) == len;
    rest_mask = eff_mask & ~(NDIGITS'(1) << pos);
    last      = end_dig && (rest_mask == '0);

    load = !out_valid_r || out_ch.ready;
    emit = load && !empty;
    pop  = emit && (head.oor || last);
  end

  always_comb begin
    out_valid_nxt = load ? !empty : out_valid_r;
    out_char_nxt  = out_char_r;
    out_oor_nxt   = out_oor_r;
    out_last_nxt  = out_last_r;
    started_nxt   = started_r;
    mask_nxt      = mask_r;
    k_nxt         = k_r;
    if (emit) begin
      if (head.oor) begin
        out_char_nxt = CHAR_NONE;
        out_oor_nxt  = 1'b1;
        out_last_nxt = 1'b1;
        started_nxt  = 1'b0;
        k_nxt        = 2'd0;
      end else begin
        out_char_nxt = digit_char(pos, d, k_r);
        out_oor_nxt  = 1'b0;
        out_last_nxt = last;
        if (end_dig) begin
          k_nxt       = 2'd0;
          mask_nxt    = rest_mask;
          started_nxt = !last;
        end else begin
          k_nxt       = k_r + 2'd1;
          mask_nxt    = eff_mask;
          started_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      mask_r      <= '0;
      k_r         <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      mask_r      <= mask_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_oor_r  <= out_oor_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### design/integer_to_roman_numeral_core.sv
`timescale 1ns / 1ps
// Integer to Roman numeral converter.
// in_ch carries one 13-bit unsigned value per request (valid/ready). out_ch
// returns the numeral as ASCII characters, one per request, with last_char
// set on the final one. A value of zero or above 4999 gives one request with
// numeral_char 0, out_of_range 1 and last_char 1.
// The front takes a value when idle and splits a value in range into decimal
// digits, one digit per cycle by parallel threshold compares (thousands,
// hundreds, tens, with the units left as the remainder), then queues it; it
// takes no new value until the entry is pushed into the two-entry queue. The
// back emits one character per cycle from the queue head through a registered
// output while the receiver is ready; a numeral has 1 to 16 characters.
// The first character comes out of the back's output register after the
// split and the queue write. When the receiver stalls, the output holds; the
// queue fills and then the front stops taking values. Reset (rst_n low,
// synchronous) empties the queue and drops any partial numeral.
module integer_to_roman_numeral_core (
  input  logic   clk,
  input  logic   rst_n,
  rn_in_if.sink  in_ch,
  rn_out_if.source out_ch
);
  import rn_pkg::*;

  logic      push, full, pop, empty;
  rn_entry_t push_entry, head;

  rn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  rn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  rn_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### design/rn_checker.sv
`timescale 1ns / 1ps
module rn_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input rn_pkg::char_t out_char,
  input logic          out_oor,
  input logic          out_last
);
  import rn_pkg::*;

  a_flag_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_oor |-> out_last && out_char == CHAR_NONE)
    else $error("flagged request is not a lone final request");

  a_char_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_oor |-> out_char == CHAR_M || out_char == CHAR_D ||
      out_char == CHAR_C || out_char == CHAR_L || out_char == CHAR_X ||
      out_char == CHAR_V || out_char == CHAR_I)
    else $error("character is not a numeral symbol");

  a_reset_quiet : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(out_oor) && $stable(out_last))
    else $error("stalled output request changed");

endmodule

bind integer_to_roman_numeral_core rn_checker u_rn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.numeral_char),
  .out_oor   (out_ch.out_of_range),
  .out_last  (out_ch.last_char)
);
